// ===== rtl/swe_pkg.sv =====
// Shared types and constants for the sliding window enumerator.
package swe_pkg;

    localparam int DATA_W      = 64;
    localparam int MAX_WINDOWS = 64;
    localparam int CNT_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int IN_TDATA_W  = 2 * DATA_W;
    localparam int OUT_TDATA_W = 2 * DATA_W;
    localparam int STATUS_W    = 2;
    localparam int CFG_ADDR_W  = 1;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SIZE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SLIDE = 1'b1;

    typedef logic [DATA_W-1:0] t_word;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID      = 2'd0,
        ST_NONE       = 2'd1,
        ST_ZERO_SLIDE = 2'd2,
        ST_TRUNC      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MOD1,
        S_MOD2,
        S_CHECK,
        S_EMIT,
        S_ONE
    } t_state;

    // Request and response of the shared modulo unit
    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word rem;
    } t_div_rsp;

endpackage

// ===== rtl/swe_mod_unit.sv =====
// Bit-serial restoring modulo unit, one quotient bit per cycle.
module swe_mod_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swe_pkg::t_div_req  i_req,
    output swe_pkg::t_div_rsp  o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [swe_pkg::DIV_CNT_W-1:0]  r_cnt;
    swe_pkg::t_word                 r_rem;
    swe_pkg::t_word                 r_dvd;
    swe_pkg::t_word                 r_dvs;

    logic [swe_pkg::DATA_W:0]       w_shift;
    logic [swe_pkg::DATA_W:0]       w_diff;
    swe_pkg::t_word                 n_rem;

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_shift = {r_rem, r_dvd[swe_pkg::DATA_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        if (!w_diff[swe_pkg::DATA_W]) begin
            n_rem = w_diff[swe_pkg::DATA_W-1:0];
        end else begin
            n_rem = w_shift[swe_pkg::DATA_W-1:0];
        end
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == swe_pkg::DIV_CNT_W'(swe_pkg::DATA_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[swe_pkg::DATA_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/sliding_window_enumerator_core.sv =====
// Sliding window enumerator: lists every window that holds a slice, up to MAX_WINDOWS.
// An accepted word passes prep, the bit-serial modulo unit (twice when the slice
// starts at or past the first window end, once otherwise), a check, then emission;
// a zero slide goes straight to a single result. Results leave one per cycle while
// the sink is ready; no new word is taken until the last result has been pushed.
// Reset (sync, active low) returns to idle, empties the output register, sets size/slide 1.
module sliding_window_enumerator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [swe_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [swe_pkg::DATA_W-1:0]          i_cfg_wdata,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [swe_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // slice_start, deployment_time
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [swe_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // window_start, window_end
    output logic [swe_pkg::STATUS_W-1:0]        m_axis_tuser,  // status
    output logic                                m_axis_tlast   // last
);

    swe_pkg::t_state            r_state;
    swe_pkg::t_state            n_state;

    swe_pkg::t_word             r_size;
    swe_pkg::t_word             r_slide;

    swe_pkg::t_word             r_s;
    swe_pkg::t_word             r_sum;
    swe_pkg::t_word             r_sd;
    swe_pkg::t_word             r_sps;
    swe_pkg::t_word             r_spz;
    swe_pkg::t_word             r_first;
    swe_pkg::t_word             r_lastend;
    swe_pkg::t_word             r_cur;
    logic [swe_pkg::CNT_W-1:0]  r_n;
    swe_pkg::t_status           r_special;

    logic                       r_out_valid;
    swe_pkg::t_word             r_out_start;
    swe_pkg::t_word             r_out_end;
    swe_pkg::t_status           r_out_status;
    logic                       r_out_last;

    swe_pkg::t_div_req          w_div_req;
    swe_pkg::t_div_rsp          w_div_rsp;

    logic                       w_in_acc;
    logic                       w_slot_free;
    logic                       w_early;
    swe_pkg::t_word             w_next;
    logic                       w_more;
    logic                       w_at_cap;
    logic                       w_push;
    swe_pkg::t_word             w_push_start;
    swe_pkg::t_word             w_push_end;
    swe_pkg::t_status           w_push_status;
    logic                       w_push_last;

    swe_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Shared compare and step logic
    always_comb begin
        w_in_acc    = s_axis_tvalid && s_axis_tready;
        w_slot_free = !r_out_valid || m_axis_tready;
        w_early     = r_s < r_sum;
        w_next      = r_cur + r_slide;
        w_more      = w_next <= r_lastend;
        w_at_cap    = r_n == swe_pkg::CNT_W'(swe_pkg::MAX_WINDOWS - 1);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swe_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (r_slide == '0) ? swe_pkg::S_ONE : swe_pkg::S_PREP;
                end
            end
            swe_pkg::S_PREP: begin
                n_state = w_early ? swe_pkg::S_MOD2 : swe_pkg::S_MOD1;
            end
            swe_pkg::S_MOD1: begin
                if (w_div_rsp.done) begin
                    n_state = swe_pkg::S_MOD2;
                end
            end
            swe_pkg::S_MOD2: begin
                if (w_div_rsp.done) begin
                    n_state = swe_pkg::S_CHECK;
                end
            end
            swe_pkg::S_CHECK: begin
                n_state = (r_first > r_lastend) ? swe_pkg::S_ONE : swe_pkg::S_EMIT;
            end
            swe_pkg::S_EMIT: begin
                if (w_slot_free && (!w_more || w_at_cap)) begin
                    n_state = swe_pkg::S_IDLE;
                end
            end
            swe_pkg::S_ONE: begin
                if (w_slot_free) begin
                    n_state = swe_pkg::S_IDLE;
                end
            end
            default: n_state = swe_pkg::S_IDLE;
        endcase
    end

    // State outputs: modulo requests and result pushes
    always_comb begin
        s_axis_tready      = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_sd;
        w_div_req.divisor  = r_slide;
        w_push             = 1'b0;
        w_push_start       = '0;
        w_push_end         = '0;
        w_push_status      = swe_pkg::ST_VALID;
        w_push_last        = 1'b1;
        case (r_state)
            swe_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            swe_pkg::S_PREP: begin
                w_div_req.start = 1'b1;
                if (!w_early) begin
                    w_div_req.dividend = r_s - r_sum;
                end
            end
            swe_pkg::S_MOD1: begin
                w_div_req.start = w_div_rsp.done;
            end
            swe_pkg::S_EMIT: begin
                w_push       = w_slot_free;
                w_push_start = r_cur - r_size;
                w_push_end   = r_cur;
                w_push_last  = !w_more || w_at_cap;
                if (w_more && w_at_cap) begin
                    w_push_status = swe_pkg::ST_TRUNC;
                end
            end
            swe_pkg::S_ONE: begin
                w_push        = w_slot_free;
                w_push_status = r_special;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= swe_pkg::DATA_W'(1);
            r_slide <= swe_pkg::DATA_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                swe_pkg::REG_SIZE:  r_size  <= i_cfg_wdata;
                swe_pkg::REG_SLIDE: r_slide <= i_cfg_wdata;
                default:            r_size  <= r_size;
            endcase
        end
    end

    // Window bound datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            swe_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_s       <= s_axis_tdata[swe_pkg::DATA_W-1:0];
                    r_sum     <= s_axis_tdata[swe_pkg::IN_TDATA_W-1:swe_pkg::DATA_W] + r_size;
                    r_sd      <= s_axis_tdata[swe_pkg::DATA_W-1:0]
                               - s_axis_tdata[swe_pkg::IN_TDATA_W-1:swe_pkg::DATA_W];
                    r_sps     <= s_axis_tdata[swe_pkg::DATA_W-1:0] + r_slide;
                    r_spz     <= s_axis_tdata[swe_pkg::DATA_W-1:0] + r_size;
                    r_special <= swe_pkg::ST_ZERO_SLIDE;
                end
            end
            swe_pkg::S_PREP: begin
                if (w_early) begin
                    r_first <= r_sum;
                end
            end
            swe_pkg::S_MOD1: begin
                if (w_div_rsp.done) begin
                    r_first <= r_sps - w_div_rsp.rem;
                end
            end
            swe_pkg::S_MOD2: begin
                if (w_div_rsp.done) begin
                    r_lastend <= r_spz - w_div_rsp.rem;
                end
            end
            swe_pkg::S_CHECK: begin
                r_cur     <= r_first;
                r_n       <= '0;
                r_special <= swe_pkg::ST_NONE;
            end
            swe_pkg::S_EMIT: begin
                if (w_push) begin
                    r_cur <= w_next;
                    r_n   <= r_n + 1'b1;
                end
            end
            default: begin
                r_cur <= r_cur;
            end
        endcase
    end

    // Output register: refill whenever the current word leaves or the slot is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_out_valid <= w_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && w_push) begin
            r_out_start  <= w_push_start;
            r_out_end    <= w_push_end;
            r_out_status <= w_push_status;
            r_out_last   <= w_push_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_end, r_out_start};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // Modulo results only arrive while the sequencer waits for them
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == swe_pkg::S_MOD1 || r_state == swe_pkg::S_MOD2))
        else $error("modulo result outside a wait state");

    // A truncated window always closes its run
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == swe_pkg::ST_TRUNC) |-> r_out_last)
        else $error("truncated result without last");

    // Error and empty results stand alone
    a_special_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == swe_pkg::ST_NONE
                      || r_out_status == swe_pkg::ST_ZERO_SLIDE)) |-> r_out_last)
        else $error("special result without last");

    // An accepted word always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != swe_pkg::S_IDLE))
        else $error("accepted word left the sequencer idle");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the sliding window enumerator core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        swe_pkg::t_word   wstart;
        swe_pkg::t_word   wend;
        swe_pkg::t_status status;
        logic             last;
    } t_window;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_wr_en   = 1'b0;
    logic [swe_pkg::CFG_ADDR_W-1:0]  i_cfg_addr    = swe_pkg::REG_SIZE;
    logic [swe_pkg::DATA_W-1:0]      i_cfg_wdata   = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [swe_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // slice_start, deployment_time
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [swe_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // window_start, window_end
    logic [swe_pkg::STATUS_W-1:0]    m_axis_tuser;        // status
    logic                            m_axis_tlast;

    // Shadow copy of the window registers
    swe_pkg::t_word size_cfg  = 64'd1;
    swe_pkg::t_word slide_cfg = 64'd1;

    logic [swe_pkg::IN_TDATA_W-1:0] slice_words[$];
    t_window               window_q[$];
    int                    words_queued   = 0;
    int                    words_taken    = 0;
    int                    mismatch_count = 0;
    bit                    in_fire        = 1'b0;
    bit                    idle_enable    = 1'b1;
    bit                    long_stall_arm = 1'b0;
    bit                    long_stall_done = 1'b0;
    int                    src_gap        = 0;
    int                    sink_wait      = 0;

    sliding_window_enumerator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic swe_pkg::t_word rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_window(input swe_pkg::t_word ws, input swe_pkg::t_word we,
                               input swe_pkg::t_status st, input logic lst);
        t_window w;
        w.wstart = ws;
        w.wend   = we;
        w.status = st;
        w.last   = lst;
        window_q.push_back(w);
    endtask

    // List every window holding the slice, up to MAX_WINDOWS, in ascending order of end time
    task automatic enumerate_windows(input swe_pkg::t_word s, input swe_pkg::t_word d);
        swe_pkg::t_word first_end;
        swe_pkg::t_word last_end;
        swe_pkg::t_word cur_end;
        swe_pkg::t_word next_end;
        int    n;
        bit    done;
        if (slide_cfg == '0) begin
            push_window('0, '0, swe_pkg::ST_ZERO_SLIDE, 1'b1);
            return;
        end
        first_end = d + size_cfg;
        if (s >= first_end) begin
            first_end = s - ((s - size_cfg - d) % slide_cfg) + slide_cfg;
        end
        last_end = s - ((s - d) % slide_cfg) + size_cfg;
        if (first_end > last_end) begin
            push_window('0, '0, swe_pkg::ST_NONE, 1'b1);
            return;
        end
        cur_end = first_end;
        n       = 0;
        done    = 1'b0;
        while (!done) begin
            next_end = cur_end + slide_cfg;
            if (next_end > last_end) begin
                push_window(cur_end - size_cfg, cur_end, swe_pkg::ST_VALID, 1'b1);
                done = 1'b1;
            end else if (n == swe_pkg::MAX_WINDOWS - 1) begin
                // Cut the run off and flag the last window sent
                push_window(cur_end - size_cfg, cur_end, swe_pkg::ST_TRUNC, 1'b1);
                done = 1'b1;
            end else begin
                push_window(cur_end - size_cfg, cur_end, swe_pkg::ST_VALID, 1'b0);
                n++;
                cur_end = next_end;
            end
        end
    endtask

    // Sample both handshakes at the rising edge; predict and check
    always @(posedge i_clk) begin
        t_window w;
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) begin
            words_taken++;
            enumerate_windows(s_axis_tdata[swe_pkg::DATA_W-1:0],
                              s_axis_tdata[2*swe_pkg::DATA_W-1:swe_pkg::DATA_W]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (window_q.size() == 0) begin
                $error("unexpected result word: tdata=%h tuser=%0d tlast=%0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatch_count++;
            end else begin
                w = window_q.pop_front();
                if (m_axis_tdata[swe_pkg::DATA_W-1:0] !== w.wstart) begin
                    $error("window_start: expected %0d, actual %0d",
                           w.wstart, m_axis_tdata[swe_pkg::DATA_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[2*swe_pkg::DATA_W-1:swe_pkg::DATA_W] !== w.wend) begin
                    $error("window_end: expected %0d, actual %0d",
                           w.wend, m_axis_tdata[2*swe_pkg::DATA_W-1:swe_pkg::DATA_W]);
                    mismatch_count++;
                end
                if (m_axis_tuser !== w.status) begin
                    $error("status: expected %0d, actual %0d", w.status, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tlast !== w.last) begin
                    $error("last: expected %0b, actual %0b", w.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Source driver: hold the word until taken, then idle or offer the next
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (slice_words.size() > 0) begin
                s_axis_tdata  <= slice_words.pop_front();
                s_axis_tvalid <= 1'b1;
                if (idle_enable && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(1, 12);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink: random back-pressure bursts plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (long_stall_arm && !long_stall_done) begin
            long_stall_done = 1'b1;
            sink_wait = 600;
            m_axis_tready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            m_axis_tready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            sink_wait = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic offer_slice(input swe_pkg::t_word s, input swe_pkg::t_word d);
        slice_words.push_back({d, s});
        words_queued++;
    endtask

    // Wait until every queued word is taken and every result has come back
    task automatic drain();
        while (words_taken != words_queued || window_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [swe_pkg::CFG_ADDR_W-1:0] idx,
                             input swe_pkg::t_word val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == swe_pkg::REG_SIZE) begin
            size_cfg = val;
        end else begin
            slide_cfg = val;
        end
    endtask

    task automatic set_windows(input swe_pkg::t_word sz, input swe_pkg::t_word sl);
        drain();
        write_reg(swe_pkg::REG_SIZE, sz);
        write_reg(swe_pkg::REG_SLIDE, sl);
    endtask

    function automatic swe_pkg::t_word pick_slide();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3: return swe_pkg::t_word'($urandom_range(1, 8));
            4, 5:    return swe_pkg::t_word'($urandom_range(1, 100));
            6:       return swe_pkg::t_word'($urandom_range(1, 1 << 20));
            7:       return rand64();
            8:       return '1;
            default: return swe_pkg::t_word'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic swe_pkg::t_word pick_size(input swe_pkg::t_word sl);
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return sl * $urandom_range(1, 80);
            3:       return sl * $urandom_range(1, 70) + $urandom_range(0, 3) - 1;
            4, 5, 6: return swe_pkg::t_word'($urandom_range(1, 300));
            7:       return rand64();
            8:       return '1;
            default: return sl;
        endcase
    endfunction

    // Place most slices near the deployment time so that windows exist
    task automatic offer_random_slice();
        swe_pkg::t_word d;
        swe_pkg::t_word s;
        logic [65:0]    span;
        d = ($urandom_range(0, 1) == 0) ? rand64()
                                        : swe_pkg::t_word'($urandom_range(0, 1000));
        span = 66'(size_cfg) + 66'(slide_cfg) * 4 + 1;
        case ($urandom_range(0, 9))
            0: s = rand64();
            1: s = d - $urandom_range(1, 50);
            2: s = d + size_cfg + $urandom_range(0, 2) - 1;
            3: s = '1 - $urandom_range(0, 3);
            default: begin
                if (span[65:64] != 2'b00) begin
                    s = d + rand64();
                end else begin
                    s = d + (rand64() % span[63:0]);
                end
            end
        endcase
        offer_slice(s, d);
    endtask

    initial begin
        swe_pkg::t_word sl;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: size 1, slide 1
        offer_slice('0, '0);
        offer_slice('1, '1);
        offer_slice('1, '0);
        offer_slice('0, '1);
        offer_slice(64'd5, 64'd3);

        // Ordinary windows, around the first-window boundary and before deployment
        set_windows(64'd10, 64'd3);
        offer_slice(64'd105, 64'd100);
        offer_slice(64'd110, 64'd100);
        offer_slice(64'd109, 64'd100);
        offer_slice(64'd99, 64'd100);
        offer_slice(64'd1100, 64'd100);

        // Zero slide
        set_windows(64'd10, 64'd0);
        offer_slice(rand64(), rand64());
        offer_slice('0, '0);

        // Exactly the window limit, then one past it, then far past it
        set_windows(64'd64, 64'd1);
        offer_slice(64'd1000, 64'd0);
        set_windows(64'd65, 64'd1);
        offer_slice(64'd1000, 64'd0);
        set_windows(64'd200, 64'd1);
        offer_slice(64'd1000, 64'd0);

        // Zero size gives no windows
        set_windows(64'd0, 64'd5);
        offer_slice(64'd17, 64'd3);
        offer_slice(64'd2, 64'd3);

        // Largest size and slide
        set_windows('1, '1);
        offer_slice('0, '0);
        offer_slice('1, 64'd1);
        offer_slice(rand64(), rand64());

        // Random settings, twenty slices each
        for (int p = 0; p < 11; p++) begin
            sl = pick_slide();
            set_windows(pick_size(sl), sl);
            if (p >= 9) begin
                idle_enable = 1'b0;
            end
            for (int k = 0; k < 20; k++) begin
                offer_random_slice();
            end
            if (p == 2) begin
                long_stall_arm = 1'b1;
            end
        end

        drain();
        repeat (150) @(negedge i_clk);
        if (window_q.size() != 0) begin
            $error("%0d expected results never arrived", window_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #25_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
